/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/s2l_pkg.sv */
// ----------------------------------------------------------------------------
// s2l_pkg
// types, constants and tables shared by the sRGB to CIELAB pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package s2l_pkg;

   localparam int LANES      = 3;
   localparam int CBRT_BITS  = 31;

   localparam int LIN_STAGES   = 1;
   localparam int ROW_STAGES   = 2;
   localparam int DIV_STAGES   = 3;
   localparam int CBRT_STAGES  = 2 * CBRT_BITS;
   localparam int COMP_STAGES  = CBRT_STAGES + 1;
   localparam int MERGE_STAGES = 2;
   localparam int PIPE_DEPTH   = LIN_STAGES + ROW_STAGES + DIV_STAGES + COMP_STAGES
                                 + MERGE_STAGES;
   localparam int LINPATH_STAGES = 1 + DIV_STAGES + 1;
   localparam int LIN_DELAY      = CBRT_STAGES - LINPATH_STAGES;

   // divide by constant: q = ((n >> shift) * recip) >> 32, then up to 3 corrections
   typedef struct packed {
      logic [4:0]  shift;
      logic [31:0] recip;
      logic [16:0] divisor;
   } div_const_type;

   localparam div_const_type DIV_X = '{shift: 5'd16,
      recip: 32'((64'd1 << 48) / 64'd95047), divisor: 17'd95047};
   localparam div_const_type DIV_Y = '{shift: 5'd13,
      recip: 32'((64'd1 << 45) / 64'd10000), divisor: 17'd10000};
   localparam div_const_type DIV_Z = '{shift: 5'd16,
      recip: 32'((64'd1 << 48) / 64'd108883), divisor: 17'd108883};
   localparam div_const_type DIV_LIN = '{shift: 5'd6,
      recip: 32'((64'd1 << 38) / 64'd1000), divisor: 17'd1000};

   typedef struct packed {
      logic [13:0]   coef_r;
      logic [13:0]   coef_g;
      logic [13:0]   coef_b;
      logic          scale10;
      div_const_type div;
   } row_type;

   typedef row_type row_set_type [LANES];

   localparam row_set_type LANE_ROWS = '{
      '{coef_r: 14'd4124, coef_g: 14'd3576, coef_b: 14'd1805, scale10: 1'b1, div: DIV_X},
      '{coef_r: 14'd2126, coef_g: 14'd7152, coef_b: 14'd722,  scale10: 1'b0, div: DIV_Y},
      '{coef_r: 14'd193,  coef_g: 14'd1192, coef_b: 14'd9505, scale10: 1'b1, div: DIV_Z}
   };

   localparam logic [12:0] COMP_GAIN   = 13'd7787;
   localparam logic [19:0] COMP_SCALE  = 20'd1000000;
   localparam logic [43:0] COMP_KNEE   = 44'(64'd8856 << 30);
   localparam logic [31:0] COMP_OFFSET = 32'((64'd16 << 30) / 64'd116);

   typedef logic [30:0] lin_table_type [256];

   function automatic lin_table_type lin_table_build();
      lin_table_type    tbl;
      longint unsigned  tq;
      longint unsigned  w;
      longint unsigned  y;
      longint unsigned  cand;
      longint unsigned  p;
      longint unsigned  q_one;
      q_one = 64'd1 << 30;
      for (int c = 0; c < 256; c++) begin
         if (c <= 10) begin
            tbl[c] = 31'(((64'(c) << 30) * 64'd10) / 64'd32946);
         end else begin
            tq = ((64'd1000 * 64'(c) + 64'd14025) << 30) / 64'd269025;
            w  = (tq * tq) >> 30;
            y  = 0;
            for (int bit_i = 30; bit_i >= 0; bit_i--) begin
               cand = y | (64'd1 << bit_i);
               if (cand <= q_one) begin
                  p = (cand * cand) >> 30;
                  p = (p * cand) >> 30;
                  p = (p * cand) >> 30;
                  p = (p * cand) >> 30;
                  if (p <= w) begin
                     y = cand;
                  end
               end
            end
            tbl[c] = 31'((w * y) >> 30);
         end
      end
      return tbl;
   endfunction

   localparam lin_table_type LIN_TABLE = lin_table_build();

endpackage

`default_nettype wire

/* hdl/s2l_div.sv */
// ----------------------------------------------------------------------------
// s2l_div
// three-stage divide by a constant using a reciprocal and remainder correction
// ----------------------------------------------------------------------------
`default_nettype none

module s2l_div (
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire s2l_pkg::div_const_type cfg,
   input  wire logic [47:0]            numer,
   output logic [31:0]                 quot
);
   import s2l_pkg::*;

   logic [47:0] nsh;
   logic [63:0] est_prod;
   logic [31:0] est1_ff;
   logic [47:0] num1_ff;
   logic [48:0] qd2_ff;
   logic [31:0] est2_ff;
   logic [47:0] num2_ff;
   logic [49:0] rem;
   logic [1:0]  corr;
   logic [31:0] quot_ff;

   assign nsh      = numer >> cfg.shift;
   assign est_prod = nsh[31:0] * cfg.recip;

   assign rem  = {2'b00, num2_ff} - {1'b0, qd2_ff};
   assign corr = 2'(rem >= 50'(cfg.divisor)) + 2'(rem >= 50'({cfg.divisor, 1'b0}))
                 + 2'(rem >= (50'(cfg.divisor) * 50'd3));

   always_ff @(posedge clock) begin
      if (enable) begin
         est1_ff <= est_prod[63:32];
         num1_ff <= numer;
         qd2_ff  <= est1_ff * cfg.divisor;
         est2_ff <= est1_ff;
         num2_ff <= num1_ff;
         quot_ff <= est2_ff + 32'(corr);
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

/* hdl/s2l_cbrt.sv */
// ----------------------------------------------------------------------------
// s2l_cbrt
// pipelined Q30 cube root, one result bit per two stages
// ----------------------------------------------------------------------------
`default_nettype none

module s2l_cbrt (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [31:0] value,
   output logic [30:0]      root
);
   import s2l_pkg::*;

   logic [30:0] y_at  [CBRT_BITS+1];
   logic [31:0] v_at  [CBRT_BITS+1];
   logic [30:0] y_ff  [CBRT_BITS];
   logic [31:0] vb_ff [CBRT_BITS];
   logic [30:0] cand_ff [CBRT_BITS];
   logic [31:0] sq_ff   [CBRT_BITS];
   logic [31:0] va_ff   [CBRT_BITS];

   assign y_at[0] = '0;
   assign v_at[0] = value;

   for (genvar k = 0; k < CBRT_BITS; k++) begin : g_step
      logic [30:0] cand;
      logic [61:0] sq_prod;
      logic [62:0] cube_prod;
      logic [32:0] cube;

      assign cand      = y_at[k] | (31'd1 << (CBRT_BITS - 1 - k));
      assign sq_prod   = cand * cand;
      assign cube_prod = sq_ff[k] * cand_ff[k];
      assign cube      = cube_prod[62:30];

      always_ff @(posedge clock) begin
         if (enable) begin
            cand_ff[k] <= cand;
            sq_ff[k]   <= sq_prod[61:30];
            va_ff[k]   <= v_at[k];
            vb_ff[k]   <= va_ff[k];
            if (cube <= {1'b0, va_ff[k]}) begin
               y_ff[k] <= cand_ff[k];
            end else begin
               y_ff[k] <= cand_ff[k] & ~(31'd1 << (CBRT_BITS - 1 - k));
            end
         end
      end

      assign y_at[k+1] = y_ff[k];
      assign v_at[k+1] = vb_ff[k];
   end

   assign root = y_at[CBRT_BITS];

endmodule

`default_nettype wire

/* hdl/s2l_lane.sv */
// ----------------------------------------------------------------------------
// s2l_lane
// one XYZ lane: matrix row, white-point divide and CIE companding
// ----------------------------------------------------------------------------
`default_nettype none

module s2l_lane (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire s2l_pkg::row_type row,
   input  wire logic [30:0]      lin_r,
   input  wire logic [30:0]      lin_g,
   input  wire logic [30:0]      lin_b,
   output logic [31:0]           lab_f
);
   import s2l_pkg::*;

   logic [44:0] pr_ff;
   logic [44:0] pg_ff;
   logic [44:0] pb_ff;
   logic [45:0] row_sum;
   logic [47:0] num_in;
   logic [47:0] num_ff;
   logic [31:0] norm;

   assign row_sum = 46'(pr_ff) + 46'(pg_ff) + 46'(pb_ff);
   assign num_in  = row.scale10 ? (48'(row_sum) * 48'd10) : 48'(row_sum);

   always_ff @(posedge clock) begin
      if (enable) begin
         pr_ff  <= lin_r * row.coef_r;
         pg_ff  <= lin_g * row.coef_g;
         pb_ff  <= lin_b * row.coef_b;
         num_ff <= num_in;
      end
   end

   s2l_div u_div (
      .clock  (clock),
      .enable (enable),
      .cfg    (row.div),
      .numer  (num_ff),
      .quot   (norm)
   );

   // cube-root segment
   logic [30:0] root;

   s2l_cbrt u_cbrt (
      .clock  (clock),
      .enable (enable),
      .value  (norm),
      .root   (root)
   );

   // linear segment and knee select
   logic [51:0] knee_prod;
   logic        knee;
   logic [44:0] gain_ff;
   logic [31:0] lin_q;
   logic [31:0] lin_res_ff;
   logic [31:0] lin_line_ff [LIN_DELAY];
   logic        knee_line_ff [CBRT_STAGES];
   logic [31:0] lab_f_ff;

   assign knee_prod = norm * COMP_SCALE;
   assign knee      = knee_prod > 52'(COMP_KNEE);

   always_ff @(posedge clock) begin
      if (enable) begin
         gain_ff <= norm * COMP_GAIN;
      end
   end

   s2l_div u_lin_div (
      .clock  (clock),
      .enable (enable),
      .cfg    (DIV_LIN),
      .numer  (48'(gain_ff)),
      .quot   (lin_q)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         lin_res_ff      <= lin_q + COMP_OFFSET;
         lin_line_ff[0]  <= lin_res_ff;
         knee_line_ff[0] <= knee;
         for (int i = 1; i < LIN_DELAY; i++) begin
            lin_line_ff[i] <= lin_line_ff[i-1];
         end
         for (int i = 1; i < CBRT_STAGES; i++) begin
            knee_line_ff[i] <= knee_line_ff[i-1];
         end
         lab_f_ff <= knee_line_ff[CBRT_STAGES-1] ? 32'(root)
                                                 : lin_line_ff[LIN_DELAY-1];
      end
   end

   assign lab_f = lab_f_ff;

endmodule

`default_nettype wire

/* hdl/s2l_merge.sv */
// ----------------------------------------------------------------------------
// s2l_merge
// combines the three lanes into L*, a*, b* with rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module s2l_merge (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [31:0] fx,
   input  wire logic [31:0] fy,
   input  wire logic [31:0] fz,
   output logic [14:0]      lightness,
   output logic [15:0]      green_red_axis,
   output logic [15:0]      blue_yellow_axis
);
   import s2l_pkg::*;

   localparam logic signed [43:0] HALF_Q8 = 44'sd2097152;
   localparam logic signed [43:0] L_BIAS  = 44'sd17179869184;

   logic signed [32:0] dxy;
   logic signed [32:0] dyz;
   logic signed [43:0] lv_ff;
   logic signed [43:0] av_ff;
   logic signed [43:0] bv_ff;
   logic signed [43:0] l_clamp;
   logic signed [43:0] l8;
   logic signed [43:0] a8;
   logic signed [43:0] b8;
   logic [14:0]        l_ff;
   logic [15:0]        a_ff;
   logic [15:0]        b_ff;

   assign dxy = $signed({1'b0, fx}) - $signed({1'b0, fy});
   assign dyz = $signed({1'b0, fy}) - $signed({1'b0, fz});

   assign l_clamp = lv_ff[43] ? '0 : lv_ff;
   assign l8      = (l_clamp + HALF_Q8) >>> 22;
   assign a8      = (av_ff + HALF_Q8) >>> 22;
   assign b8      = (bv_ff + HALF_Q8) >>> 22;

   function automatic logic [15:0] sat16(input logic signed [43:0] v);
      if (v > 44'sd32767) begin
         return 16'h7fff;
      end else if (v < -44'sd32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (enable) begin
         lv_ff <= $signed({12'b0, fy}) * 44'sd116 - L_BIAS;
         av_ff <= 44'(dxy) * 44'sd500;
         bv_ff <= 44'(dyz) * 44'sd200;
         l_ff  <= (l8 > 44'sd32767) ? 15'h7fff : l8[14:0];
         a_ff  <= sat16(a8);
         b_ff  <= sat16(b8);
      end
   end

   assign lightness        = l_ff;
   assign green_red_axis   = a_ff;
   assign blue_yellow_axis = b_ff;

endmodule

`default_nettype wire

/* hdl/srgb_to_cielab_core.sv */
// ----------------------------------------------------------------------------
// srgb_to_cielab_core
// sRGB (D65, 2-degree observer) to CIELAB pixel converter
//
// Input channel req_*: one 24-bit sRGB pixel per item, red in the top byte.
// Output channel rsp_*: one L*a*b* triple per item, all in units of 1/256.
// Each pixel is linearised by one shared 256-entry constant table per channel, then
// three lanes (X, Y, Z) form a matrix row, divide by the white point via a
// reciprocal multiply and apply the CIE companding; a merge stage builds
// L*, a*, b* with rounding, zero clamp and saturation.
// The pipeline depth is set by the cube root, which resolves one result
// bit per two stages over 31 bits.
// Throughput is one item per clock while rsp_tready is high.
// The whole pipeline advances when the output register is empty or taken;
// when the receiver stalls, the pipeline holds and req_tready falls.
// Reset clears all valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_to_cielab_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // packed_color[23:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // lightness[14:0], green_red_axis[30:15],
                                         // blue_yellow_axis[46:31], zero[47]
);
   import s2l_pkg::*;

   logic              advance;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [30:0]       lin_ff [LANES];
   logic [31:0]       lab_f [LANES];
   logic [14:0]       lightness;
   logic [15:0]       green_red_axis;
   logic [15:0]       blue_yellow_axis;

   assign advance    = !valid_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lin_ff[0] <= LIN_TABLE[req_tdata[23:16]];
         lin_ff[1] <= LIN_TABLE[req_tdata[15:8]];
         lin_ff[2] <= LIN_TABLE[req_tdata[7:0]];
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      s2l_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .row    (LANE_ROWS[l]),
         .lin_r  (lin_ff[0]),
         .lin_g  (lin_ff[1]),
         .lin_b  (lin_ff[2]),
         .lab_f  (lab_f[l])
      );
   end

   s2l_merge u_merge (
      .clock            (clock),
      .enable           (advance),
      .fx               (lab_f[0]),
      .fy               (lab_f[1]),
      .fz               (lab_f[2]),
      .lightness        (lightness),
      .green_red_axis   (green_red_axis),
      .blue_yellow_axis (blue_yellow_axis)
   );

   assign rsp_tvalid = valid_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {1'b0, blue_yellow_axis, green_red_axis, lightness};

endmodule

`default_nettype wire

/* hdl/s2l_checker.sv */
// ----------------------------------------------------------------------------
// s2l_checker
// port-level checks for the sRGB to CIELAB core
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module s2l_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   `CHK_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CHK_IMPLY(a_l_range, clock, reset, rsp_tvalid, rsp_tdata[14:0] <= 15'd25600)
   `CHK_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   `CHK_IMPLY(a_ready_free, clock, reset, !rsp_tvalid, req_tready || !req_tvalid)

endmodule

bind srgb_to_cielab_core s2l_checker u_s2l_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* verif/srgb_to_cielab_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_cielab_checker
// watches both channels, computes the expected L*a*b* triple of every
// accepted pixel in Q30 fixed point and compares each accepted result
// field by field with the oldest outstanding triple
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_to_cielab_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   output int               error_count,
   output int               pending_count,
   output int               result_count
);

   localparam longint unsigned Q_ONE = 64'd1 << 30;

   typedef struct packed {
      logic [15:0] blue_yellow_axis;
      logic [15:0] green_red_axis;
      logic [14:0] lightness;
   } lab_type;

   lab_type         lab_queue [$];
   longint unsigned lin_rom [256];

   function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned linearise(int code);
      longint unsigned t, w, y, cand, p;
      if (code <= 10) return ((64'(code) << 30) * 10) / 32946;
      t = ((64'd1000 * code + 64'd14025) << 30) / 64'd269025;
      w = qmul(t, t);
      y = 0;
      for (int k = 30; k >= 0; k--) begin
         cand = y | (64'd1 << k);
         if (cand <= Q_ONE) begin
            p = qmul(qmul(qmul(qmul(cand, cand), cand), cand), cand);
            if (p <= w) y = cand;
         end
      end
      return qmul(w, y);
   endfunction

   function automatic longint unsigned cie_compand(longint unsigned v);
      longint unsigned y, cand;
      if (v * 64'd1000000 > (64'd8856 << 30)) begin
         y = 0;
         for (int k = 30; k >= 0; k--) begin
            cand = y | (64'd1 << k);
            if (qmul(qmul(cand, cand), cand) <= v) y = cand;
         end
         return y;
      end
      return (64'd7787 * v) / 1000 + (64'd16 << 30) / 116;
   endfunction

   function automatic longint round_q8(longint v);
      return (v + (64'sd1 <<< 21)) >>> 22;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic lab_type convert_pixel(logic [23:0] px);
      longint unsigned r, g, b, x, y, z;
      longint fx, fy, fz, lv, l8;
      lab_type res;
      r = lin_rom[px[23:16]];
      g = lin_rom[px[15:8]];
      b = lin_rom[px[7:0]];
      x = ((4124 * r + 3576 * g + 1805 * b) * 10) / 95047;
      y = (2126 * r + 7152 * g + 722 * b) / 10000;
      z = ((193 * r + 1192 * g + 9505 * b) * 10) / 108883;
      fx = longint'(cie_compand(x));
      fy = longint'(cie_compand(y));
      fz = longint'(cie_compand(z));
      lv = 116 * fy - (64'sd16 <<< 30);
      if (lv < 0) lv = 0;
      l8 = round_q8(lv);
      if (l8 > 32767) l8 = 32767;
      res.lightness        = 15'(l8);
      res.green_red_axis   = 16'(clip16(round_q8(500 * (fx - fy))));
      res.blue_yellow_axis = 16'(clip16(round_q8(200 * (fy - fz))));
      return res;
   endfunction

   initial begin
      for (int c = 0; c < 256; c++) lin_rom[c] = linearise(c);
   end

   always @(posedge clock) begin
      lab_type want, got;
      if (reset) begin
         error_count  <= 0;
         result_count <= 0;
      end else begin
         if (req_tvalid && req_tready) lab_queue = {lab_queue, convert_pixel(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            got = rsp_tdata[46:0];
            if (lab_queue.size() == 0) begin
               $error("result with nothing outstanding: %h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = lab_queue.pop_front();
               if (got.lightness != want.lightness || rsp_tdata[47] !== 1'b0) begin
                  $error("lightness expected %0d actual %0d (pad %b)",
                         want.lightness, got.lightness, rsp_tdata[47]);
                  error_count <= error_count + 1;
               end
               if (got.green_red_axis != want.green_red_axis) begin
                  $error("green_red_axis expected %0d actual %0d",
                         $signed(want.green_red_axis), $signed(got.green_red_axis));
                  error_count <= error_count + 1;
               end
               if (got.blue_yellow_axis != want.blue_yellow_axis) begin
                  $error("blue_yellow_axis expected %0d actual %0d",
                         $signed(want.blue_yellow_axis), $signed(got.blue_yellow_axis));
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_count = lab_queue.size();
   end

endmodule

`default_nettype wire

/* verif/srgb_to_cielab_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_cielab_core_tb
// drives directed and random sRGB pixels into the converter with random
// gaps and output stalls; a checker predicts and compares every triple
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_to_cielab_core_tb;

   localparam int RANDOM_ITEMS = 1500;
   localparam int TAIL_CYCLES  = 200;
   localparam int STALL_LIMIT  = 5000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // packed_color[23:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // lightness[14:0], green_red_axis[30:15],
                             // blue_yellow_axis[46:31], zero[47]
   int          error_count;
   int          pending_count;
   int          result_count;
   int          idle_cycles;
   bit          calm;
   logic [23:0] pixel_list [$];

   srgb_to_cielab_core dut (.*);

   srgb_to_cielab_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver stalls, none during the calm stretch
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 16);
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic logic [23:0] random_pixel();
      logic [7:0] ch [3];
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(3))
            0:       ch[k] = 8'($urandom_range(12));
            1:       ch[k] = 8'($urandom_range(255, 240));
            default: ch[k] = 8'($urandom);
         endcase
      end
      return {ch[0], ch[1], ch[2]};
   endfunction

   task automatic send_pixel(logic [23:0] px);
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      calm       = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // black, white, primaries, secondaries, knee codes, greys
      pixel_list = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                     24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h0A0A0A, 24'h0B0B0B,
                     24'h010101, 24'h808080, 24'h0A0000, 24'h000B00, 24'h00000B,
                     24'h00FF01, 24'hFF00FE, 24'h0000FE, 24'h7F7F7F, 24'h555555,
                     24'hAAAAAA, 24'h0100FF, 24'hFE01FF};
      foreach (pixel_list[k]) send_pixel(pixel_list[k]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 600 && n < 900);
         send_pixel(random_pixel());
      end
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("converted %0d pixels: directed extremes and knee codes, then random",
               result_count);
      $display("pixels under random gaps and output stalls");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
